// File: hdl/mlcd_pkg.sv
// mlcd_pkg: shared constants of the memory lcd serial line writer
// sizes of the frame store, parser phase codes, command and action codes
// no dependencies
package mlcd_pkg;

    localparam int MAX_LINE_PIXELS = 256;
    localparam int MAX_LINES       = 256;

    localparam int LINE_BYTES_MAX = MAX_LINE_PIXELS / 8;
    localparam int STORE_DEPTH    = MAX_LINES * LINE_BYTES_MAX;
    localparam int ROW_W          = $clog2(MAX_LINES);
    localparam int COL_W          = $clog2(LINE_BYTES_MAX);
    localparam int ADDR_W         = ROW_W + COL_W;
    // width used for range compares, holds every count and limit
    localparam int CMP_W          = 16;

    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 2;

    typedef logic [CMP_W-1:0]  cmp_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 9'd144;
    localparam logic [CFG_W-1:0] LINE_COUNT_RESET = 9'd168;

    // parser phases
    localparam logic [2:0] PH_COMMAND       = 3'd0;
    localparam logic [2:0] PH_DATA          = 3'd1;
    localparam logic [2:0] PH_LINE_NUMBER   = 3'd2;
    localparam logic [2:0] PH_LINE_TRAILER  = 3'd3;
    localparam logic [2:0] PH_FRAME_TRAILER = 3'd4;

    // commands
    localparam logic [7:0] CMD_MASK        = 8'hFD;
    localparam logic [7:0] CMD_VCOM        = 8'h00;
    localparam logic [7:0] CMD_CLEAR       = 8'h04;
    localparam logic [7:0] CMD_LINE_UPDATE = 8'h01;

    // actions
    localparam logic [1:0] ACT_SERIAL     = 2'd0;
    localparam logic [1:0] ACT_READ       = 2'd1;
    localparam logic [1:0] ACT_SCAN_DONE  = 2'd2;
    localparam logic [1:0] ACT_INVALIDATE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN    = 2'd1;
    localparam logic [1:0] ERR_LINE_RANGE = 2'd2;

endpackage

// File: hdl/memory_lcd_serial_line_writer_core.sv
// memory_lcd_serial_line_writer_core: spi byte parser and line-addressed frame store
// depends on mlcd_pkg
// a result is registered and appears in the cycle after its request is accepted
// one request per cycle unless stalled; each writes or reads at most one store byte
// reset: parser state and redraw flag clear at once, then a clearing pass writes zero to
//   every frame store byte (STORE_DEPTH of them, 8192), one per cycle, with no request
//   accepted meanwhile; configuration writes are taken throughout
module memory_lcd_serial_line_writer_core
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mlcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mlcd_pkg::CFG_W-1:0]        cfg_data,

    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        action,
    input  logic [7:0]                        spi_byte,
    input  logic [7:0]                        read_row,
    input  logic [4:0]                        read_byte_column,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [7:0]                        pixel_byte,
    output logic                              redraw_pending,
    output logic [2:0]                        parser_phase,
    output logic [1:0]                        error_code
);

    // configuration
    logic [mlcd_pkg::CFG_W-1:0] line_width_reg;
    logic [mlcd_pkg::CFG_W-1:0] line_count_reg;

    // parser state
    logic [2:0] phase_reg, phase_next;
    logic [7:0] line_reg, line_next;
    logic [5:0] pos_reg, pos_next;
    logic       redraw_reg, redraw_next;

    // clearing pass
    logic [mlcd_pkg::ADDR_W:0] clr_reg;
    logic                      clearing;

    // result stage
    logic       res_valid_reg;
    logic       res_rd_ok_reg;
    logic       res_redraw_reg;
    logic [2:0] res_phase_reg;
    logic [1:0] res_err_reg;

    // frame store
    logic [7:0] store_mem [mlcd_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    logic                 accept;
    logic                 mem_we;
    mlcd_pkg::addr_t      mem_waddr;
    logic                 data_we;
    mlcd_pkg::addr_t      data_addr;
    mlcd_pkg::addr_t      rd_addr;
    logic                 rd_ok;
    logic [1:0]           err;

    mlcd_pkg::cmp_t       lines_held;
    mlcd_pkg::cmp_t       bpl;
    mlcd_pkg::cmp_t       bpl_raw;
    logic [5:0]           pos_inc;
    logic [7:0]           cmd;
    logic                 line_ok;

    assign cfg_ready = 1'b1;

    assign clearing   = ~clr_reg[mlcd_pkg::ADDR_W];
    assign item_stall = clearing | (res_valid_reg & result_stall);
    assign accept     = item_valid & ~item_stall;

    // effective geometry
    always_comb
    begin
        if (mlcd_pkg::cmp_t'(line_count_reg) > mlcd_pkg::cmp_t'(mlcd_pkg::MAX_LINES))
            lines_held = mlcd_pkg::cmp_t'(mlcd_pkg::MAX_LINES);
        else
            lines_held = mlcd_pkg::cmp_t'(line_count_reg);
        bpl_raw = mlcd_pkg::cmp_t'(line_width_reg[mlcd_pkg::CFG_W-1:3]);
        if (bpl_raw == '0)
            bpl = mlcd_pkg::cmp_t'(1);
        else if (bpl_raw > mlcd_pkg::cmp_t'(mlcd_pkg::LINE_BYTES_MAX))
            bpl = mlcd_pkg::cmp_t'(mlcd_pkg::LINE_BYTES_MAX);
        else
            bpl = bpl_raw;
    end

    // parser
    always_comb
    begin
        phase_next  = phase_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        redraw_next = redraw_reg;
        err         = mlcd_pkg::ERR_NONE;
        data_we     = 1'b0;
        cmd         = spi_byte & mlcd_pkg::CMD_MASK;
        pos_inc     = pos_reg + 6'd1;
        line_ok     = mlcd_pkg::cmp_t'(line_reg) < lines_held;
        data_addr   = {mlcd_pkg::ROW_W'(line_reg), mlcd_pkg::COL_W'(pos_reg)};
        rd_addr     = {mlcd_pkg::ROW_W'(read_row), mlcd_pkg::COL_W'(read_byte_column)};
        rd_ok       = (mlcd_pkg::cmp_t'(read_row) < lines_held)
                    && (mlcd_pkg::cmp_t'(read_byte_column) < bpl);

        case (action)
            mlcd_pkg::ACT_SERIAL:
            begin
                if (phase_reg inside {mlcd_pkg::PH_LINE_NUMBER, mlcd_pkg::PH_FRAME_TRAILER})
                begin
                    if (spi_byte == 8'd0)
                    begin
                        phase_next  = mlcd_pkg::PH_COMMAND;
                        redraw_next = 1'b1;
                    end
                    else
                    begin
                        line_next  = spi_byte;
                        pos_next   = 6'd0;
                        phase_next = mlcd_pkg::PH_DATA;
                        if (mlcd_pkg::cmp_t'(spi_byte) >= lines_held)
                            err = mlcd_pkg::ERR_LINE_RANGE;
                    end
                end
                else if (phase_reg == mlcd_pkg::PH_DATA)
                begin
                    data_we  = line_ok && (mlcd_pkg::cmp_t'(pos_reg) < bpl);
                    pos_next = pos_inc;
                    if ((mlcd_pkg::cmp_t'(pos_inc) >= bpl) || (pos_inc == 6'd0))
                        phase_next = mlcd_pkg::PH_LINE_TRAILER;
                end
                else if (phase_reg == mlcd_pkg::PH_LINE_TRAILER)
                begin
                    phase_next = mlcd_pkg::PH_LINE_NUMBER;
                end
                else
                begin
                    if (cmd == mlcd_pkg::CMD_VCOM)
                        phase_next = mlcd_pkg::PH_COMMAND;
                    else if (cmd == mlcd_pkg::CMD_CLEAR)
                        phase_next = mlcd_pkg::PH_FRAME_TRAILER;
                    else if (cmd == mlcd_pkg::CMD_LINE_UPDATE)
                        phase_next = mlcd_pkg::PH_LINE_NUMBER;
                    else
                    begin
                        phase_next = mlcd_pkg::PH_COMMAND;
                        err        = mlcd_pkg::ERR_UNKNOWN;
                    end
                end
            end
            mlcd_pkg::ACT_SCAN_DONE:  redraw_next = 1'b0;
            mlcd_pkg::ACT_INVALIDATE: redraw_next = 1'b1;
            default:                  ;
        endcase
    end

    assign mem_we    = clearing | (accept & data_we);
    assign mem_waddr = clearing ? clr_reg[mlcd_pkg::ADDR_W-1:0] : data_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= clearing ? 8'd0 : spi_byte;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == mlcd_pkg::ACT_READ))
            rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= mlcd_pkg::LINE_WIDTH_RESET;
            line_count_reg <= mlcd_pkg::LINE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mlcd_pkg::CFG_LINE_WIDTH)
                line_width_reg <= cfg_data;
            else if (cfg_index == mlcd_pkg::CFG_LINE_COUNT)
                line_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mlcd_pkg::PH_COMMAND;
            line_reg      <= 8'd0;
            pos_reg       <= 6'd0;
            redraw_reg    <= 1'b0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (accept)
            begin
                phase_reg  <= phase_next;
                line_reg   <= line_next;
                pos_reg    <= pos_next;
                redraw_reg <= redraw_next;
            end
            if (accept)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with each request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_rd_ok_reg  <= (action == mlcd_pkg::ACT_READ) && rd_ok;
            res_redraw_reg <= redraw_next;
            res_phase_reg  <= phase_next;
            res_err_reg    <= err;
        end
    end

    assign result_valid   = res_valid_reg;
    assign pixel_byte     = res_rd_ok_reg ? rdata_reg : 8'd0;
    assign redraw_pending = res_redraw_reg;
    assign parser_phase   = res_phase_reg;
    assign error_code     = res_err_reg;

endmodule

// File: verif/tb.sv
// tb: self-checking testbench for memory_lcd_serial_line_writer_core
// holds a request driver, a result sink, a frame store predictor and a checker
// depends on mlcd_pkg and the core rtl
module tb;
    import mlcd_pkg::*;

    localparam int QUIET_LIMIT = 30000;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_CAP  = 40;

    // indexes that map to no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [7:0] pix;
        logic       redraw;
        logic [2:0] phase;
        logic [1:0] err;
    } lcd_result_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  spi;
        logic [7:0]  row;
        logic [4:0]  col;
        logic        pinned;
        lcd_result_t want;
    } lcd_req_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             item_valid;
    logic             item_stall;
    logic [1:0]       action;
    logic [7:0]       spi_byte;
    logic [7:0]       read_row;
    logic [4:0]       read_byte_column;
    logic             result_valid;
    logic             result_stall;
    logic [7:0]       pixel_byte;
    logic             redraw_pending;
    logic [2:0]       parser_phase;
    logic [1:0]       error_code;

    memory_lcd_serial_line_writer_core uut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .action           (action),
        .spi_byte         (spi_byte),
        .read_row         (read_row),
        .read_byte_column (read_byte_column),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .pixel_byte       (pixel_byte),
        .redraw_pending   (redraw_pending),
        .parser_phase     (parser_phase),
        .error_code       (error_code)
    );

    // predictor state
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_count;
    logic [2:0]       ps_phase;
    logic [7:0]       ps_line;
    logic [5:0]       ps_pos;
    logic             ps_redraw;
    logic [7:0]       shadow_store [0:STORE_DEPTH-1];

    lcd_result_t pending_results [$];
    lcd_result_t pin_want;
    logic        pin_on;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_ask = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int sent_count = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int mismatches = 0;
    int quiet = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int line_bytes();
        int b;
        b = cfg_width / 8;
        if (b == 0)
            b = 1;
        if (b > LINE_BYTES_MAX)
            b = LINE_BYTES_MAX;
        return b;
    endfunction

    function automatic int lines_kept();
        return (cfg_count > MAX_LINES) ? MAX_LINES : int'(cfg_count);
    endfunction

    task automatic predict_lcd_step(input logic [1:0] act, input logic [7:0] spi,
                                    input logic [7:0] row, input logic [4:0] col,
                                    output lcd_result_t res);
        int bpl;
        int held;
        logic [7:0] cmd;
        bpl = line_bytes();
        held = lines_kept();
        res = '0;
        case (act)
            ACT_SERIAL:
            begin
                case (ps_phase)
                    PH_LINE_NUMBER, PH_FRAME_TRAILER:
                    begin
                        if (spi == 8'h00)
                        begin
                            ps_phase = PH_COMMAND;
                            ps_redraw = 1'b1;
                        end
                        else
                        begin
                            ps_line = spi;
                            ps_pos = '0;
                            ps_phase = PH_DATA;
                            if (ps_line >= held)
                                res.err = ERR_LINE_RANGE;
                        end
                    end
                    PH_DATA:
                    begin
                        // bytes of an out-of-range line are dropped
                        if (ps_line < held && ps_pos < bpl)
                            shadow_store[{ps_line, ps_pos[COL_W-1:0]}] = spi;
                        ps_pos = ps_pos + 6'd1;
                        if (ps_pos >= bpl || ps_pos == 6'd0)
                            ps_phase = PH_LINE_TRAILER;
                    end
                    PH_LINE_TRAILER:
                        ps_phase = PH_LINE_NUMBER;
                    default:
                    begin
                        cmd = spi & CMD_MASK;
                        if (cmd == CMD_VCOM)
                            ps_phase = PH_COMMAND;
                        else if (cmd == CMD_CLEAR)
                            ps_phase = PH_FRAME_TRAILER;
                        else if (cmd == CMD_LINE_UPDATE)
                            ps_phase = PH_LINE_NUMBER;
                        else
                        begin
                            ps_phase = PH_COMMAND;
                            res.err = ERR_UNKNOWN;
                        end
                    end
                endcase
            end
            ACT_READ:
            begin
                if (row < held && col < bpl)
                    res.pix = shadow_store[{row, col}];
            end
            ACT_SCAN_DONE:
                ps_redraw = 1'b0;
            default:
                ps_redraw = 1'b1;
        endcase
        res.redraw = ps_redraw;
        res.phase = ps_phase;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, what, got, want);
    endtask

    // request side prediction and result checking
    always @(posedge clk)
    begin : result_check
        lcd_result_t want;
        if (rst_n && item_valid && !item_stall)
        begin
            predict_lcd_step(action, spi_byte, read_row, read_byte_column, want);
            if (pin_on)
                want = pin_want;
            pending_results.push_back(want);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", pixel_byte, 0);
            else
            begin
                want = pending_results.pop_front();
                if (pixel_byte !== want.pix)
                    report_mismatch("pixel_byte", pixel_byte, want.pix);
                if (redraw_pending !== want.redraw)
                    report_mismatch("redraw_pending", redraw_pending, want.redraw);
                if (parser_phase !== want.phase)
                    report_mismatch("parser_phase", parser_phase, want.phase);
                if (error_code !== want.err)
                    report_mismatch("error_code", error_code, want.err);
            end
            results_seen++;
        end
    end

    // result sink, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_ask != hold_taken)
        begin
            hold_taken = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LINE_WIDTH)
            cfg_width = value;
        else if (idx == CFG_LINE_COUNT)
            cfg_count = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // entered and left just after a falling edge
    task automatic offer_request(input lcd_req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        action <= r.act;
        spi_byte <= r.spi;
        read_row <= r.row;
        read_byte_column <= r.col;
        pin_on <= r.pinned;
        pin_want <= r.want;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic offer(input logic [1:0] act, input logic [7:0] spi,
                         input logic [7:0] row, input logic [4:0] col);
        lcd_req_t r;
        r = '0;
        r.act = act;
        r.spi = spi;
        r.row = row;
        r.col = col;
        offer_request(r);
    endtask

    task automatic offer_serial(input logic [7:0] b);
        offer(ACT_SERIAL, b, 8'($urandom_range(255)), 5'($urandom_range(31)));
    endtask

    function automatic logic [7:0] pick_line();
        int held;
        held = lines_kept();
        if (held > 1 && $urandom_range(99) < 85)
            return 8'($urandom_range(held - 1, 1));
        return 8'($urandom_range(255, 1));
    endfunction

    // well-formed write frame with random content, sometimes cut short
    task automatic send_frame();
        int nl;
        int bpl;
        bpl = line_bytes();
        nl = $urandom_range(3, 1);
        offer_serial(CMD_LINE_UPDATE | (~CMD_MASK & 8'($urandom_range(255))));
        for (int i = 0; i < nl; i++)
        begin
            offer_serial(pick_line());
            for (int k = 0; k < bpl; k++)
            begin
                if ($urandom_range(99) < 2)
                    return;
                offer_serial(8'($urandom_range(255)));
            end
            offer_serial(8'($urandom_range(255)));
        end
        offer_serial(8'h00);
    endtask

    task automatic random_burst(input int n);
        int target;
        int pick;
        int held;
        logic [7:0] row;
        logic [4:0] col;
        target = sent_count + n;
        while (sent_count < target)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_frame();
            else if (pick < 75)
            begin
                held = lines_kept();
                repeat ($urandom_range(4, 1))
                begin
                    row = (held > 1 && $urandom_range(99) < 60) ?
                          8'($urandom_range(held - 1, 1)) : 8'($urandom_range(255));
                    col = ($urandom_range(99) < 70) ?
                          5'($urandom_range(line_bytes() - 1)) : 5'($urandom_range(31));
                    offer(ACT_READ, 8'($urandom_range(255)), row, col);
                end
            end
            else if (pick < 80)
                offer(ACT_SCAN_DONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      5'($urandom_range(31)));
            else if (pick < 85)
                offer(ACT_INVALIDATE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      5'($urandom_range(31)));
            else if (pick < 90)
            begin
                offer_serial(CMD_CLEAR | (~CMD_MASK & 8'($urandom_range(255))));
                offer_serial(($urandom_range(1) != 0) ? 8'h00 : pick_line());
            end
            else if (pick < 95)
                offer_serial(($urandom_range(1) != 0) ?
                             (CMD_VCOM | (~CMD_MASK & 8'($urandom_range(255)))) :
                             8'($urandom_range(255)));
            else
                offer(2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 5'($urandom_range(31)));
        end
    endtask

    // called just after a falling edge; returns once every result is in
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input int width, input int count, input int idle,
                             input int stall, input int n, input bit hold);
        write_reg(CFG_LINE_WIDTH, CFG_W'(width));
        write_reg(CFG_LINE_COUNT, CFG_W'(count));
        idle_pct = idle;
        stall_pct = stall;
        if (hold)
            hold_ask <= hold_ask + 1;
        random_burst(n);
        settle();
    endtask

    lcd_req_t plan_q [$];

    task automatic add_row(input logic [1:0] act, input logic [7:0] spi, input logic [7:0] row,
                           input logic [4:0] col, input logic pinned, input logic [7:0] pix,
                           input logic redraw, input logic [2:0] ph, input logic [1:0] err);
        lcd_req_t r;
        r.act = act;
        r.spi = spi;
        r.row = row;
        r.col = col;
        r.pinned = pinned;
        r.want.pix = pix;
        r.want.redraw = redraw;
        r.want.phase = ph;
        r.want.err = err;
        plan_q.push_back(r);
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        action = '0;
        spi_byte = '0;
        read_row = '0;
        read_byte_column = '0;
        result_stall = 1'b0;
        pin_on = 1'b0;
        pin_want = '0;
        cfg_width = LINE_WIDTH_RESET;
        cfg_count = LINE_COUNT_RESET;
        ps_phase = PH_COMMAND;
        ps_line = '0;
        ps_pos = '0;
        ps_redraw = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[addr_t'(i)] = 8'h00;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // two bytes per line, three lines, so one frame fits in a short table
        write_reg(CFG_LINE_WIDTH, 9'd16);
        write_reg(CFG_LINE_COUNT, 9'd3);
        add_row(ACT_READ,       8'h00, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_READ,       8'hFF, 8'd255, 5'd31, 1, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h00, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h02, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'hFF, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_UNKNOWN);
        add_row(ACT_SERIAL,     8'h08, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_UNKNOWN);
        add_row(ACT_SERIAL,     8'h04, 8'd0,   5'd0,  1, 8'h00, 0, PH_FRAME_TRAILER, ERR_NONE);
        add_row(ACT_SERIAL,     8'h00, 8'd0,   5'd0,  1, 8'h00, 1, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SCAN_DONE,  8'h00, 8'd0,   5'd0,  1, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_INVALIDATE, 8'h00, 8'd0,   5'd0,  1, 8'h00, 1, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h03, 8'd0,   5'd0,  1, 8'h00, 1, PH_LINE_NUMBER,   ERR_NONE);
        add_row(ACT_SERIAL,     8'h02, 8'd0,   5'd0,  1, 8'h00, 1, PH_DATA,          ERR_NONE);
        add_row(ACT_SERIAL,     8'hA5, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'hFF, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h77, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        // line at the line count: data phase with an error, bytes dropped
        add_row(ACT_SERIAL,     8'h03, 8'd0,   5'd0,  1, 8'h00, 1, PH_DATA,          ERR_LINE_RANGE);
        add_row(ACT_SERIAL,     8'h11, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h22, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h00, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_SERIAL,     8'h00, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_READ,       8'h00, 8'd2,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_READ,       8'h00, 8'd2,   5'd1,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        add_row(ACT_READ,       8'h00, 8'd2,   5'd2,  1, 8'h00, 1, PH_COMMAND,       ERR_NONE);
        add_row(ACT_READ,       8'h00, 8'd3,   5'd0,  1, 8'h00, 1, PH_COMMAND,       ERR_NONE);
        // masks to the clear command
        add_row(ACT_SERIAL,     8'h06, 8'd0,   5'd0,  0, 8'h00, 0, PH_COMMAND,       ERR_NONE);
        foreach (plan_q[i])
            offer_request(plan_q[i]);
        settle();

        run_phase(144, 168, 0,  0,  120, 0);
        run_phase(8,   1,   74, 0,  110, 0);
        run_phase(256, 256, 0,  74, 130, 0);
        run_phase(20,  5,   0,  0,  100, 1);
        run_phase(0,   0,   35, 35, 110, 0);
        write_reg(CFG_SPARE_LO, 9'h1FF);
        write_reg(CFG_SPARE_HI, 9'h000);
        run_phase(511, 511, 35, 35, 110, 0);

        $display("covered %0d requests and %0d results over %0d register writes",
                 sent_count, results_seen, cfg_writes);
        $display("line widths 0 to 511 and line counts 0 to 511, with a %0d-cycle sink hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
hdl/mlcd_pkg.sv
hdl/memory_lcd_serial_line_writer_core.sv
verif/tb.sv
